[hw/rtl/ship_pkg.sv]
package ship_pkg;

  localparam int NUM_SETS    = 2048;
  localparam int SET_W       = 11;
  localparam int NUM_WAYS    = 16;
  localparam int WAY_W       = 4;
  localparam int MASK_BITS   = 16;
  localparam int SIG_ENTRIES = 1024;
  localparam int SIG_W       = 10;
  localparam int CTR_W       = 3;
  localparam int RRPV_W      = 2;
  localparam int RRPV_MAX    = 3;

  localparam logic [CTR_W-1:0] CTR_TOP = '1;
  localparam logic [CTR_W-1:0] CTR_MID = CTR_TOP >> 1;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  localparam int USER_OPCODE_BIT = 0;
  localparam int USER_IS_HIT_BIT = 1;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HIT    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FILL   = 2'd3;

  typedef struct packed {
    logic [RRPV_W-1:0] rrpv;
    logic              valid;
    logic              reused;
    logic [SIG_W-1:0]  sig;
  } way_t;

  typedef way_t [NUM_WAYS-1:0] row_t;

  localparam way_t WAY_RESET = '{
    rrpv:   RRPV_W'(RRPV_MAX),
    valid:  1'b0,
    reused: 1'b0,
    sig:    '0
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SET_W-1:0]  set_idx;
    logic [WAY_W-1:0]  way;
    logic [SIG_W-1:0]  pc;
  } req_t;

  typedef struct packed {
    logic             inserted_hot;
    logic             found_free_way;
    logic [WAY_W-1:0] victim_way;
  } result_t;

  typedef struct packed {
    logic push;
    logic full;
  } push_ctl_t;

endpackage

[hw/rtl/ship_front.sv]
module ship_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // set_index[10:0], way_index[14:11], pc_low_bits[24:15], way_valid_mask[40:25], zero pad
  input  logic [ship_pkg::IN_DATA_W-1:0]      in_tdata,
  // opcode[0], is_hit[1]
  input  logic [ship_pkg::IN_USER_W-1:0]      in_tuser,
  input  logic                                clear_busy,
  input  logic                                q_full,
  output logic                                q_push,
  output ship_pkg::req_t                      q_req
);

  localparam int WAY_LSB  = ship_pkg::SET_W;
  localparam int PC_LSB   = WAY_LSB + ship_pkg::WAY_W;
  localparam int MASK_LSB = PC_LSB + ship_pkg::SIG_W;

  logic [ship_pkg::MASK_BITS-1:0] mask;
  logic                           free_found;
  logic [ship_pkg::WAY_W-1:0]     free_way;
  logic                           opcode;
  logic                           is_hit;

  assign mask      = in_tdata[MASK_LSB +: ship_pkg::MASK_BITS];
  assign opcode    = in_tuser[ship_pkg::USER_OPCODE_BIT];
  assign is_hit    = in_tuser[ship_pkg::USER_IS_HIT_BIT];
  assign in_tready = !q_full && !clear_busy;
  assign q_push    = in_tvalid && in_tready;

  // lowest way that the mask shows as free
  always_comb begin
    free_found = 1'b0;
    free_way   = '0;
    for (int w = ship_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (w < ship_pkg::MASK_BITS && !mask[w]) begin
        free_found = 1'b1;
        free_way   = ship_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    q_req.set_idx = in_tdata[ship_pkg::SET_W-1:0];
    q_req.pc      = in_tdata[PC_LSB +: ship_pkg::SIG_W];
    q_req.way     = in_tdata[WAY_LSB +: ship_pkg::WAY_W];
    if (opcode == ship_pkg::OP_VICTIM) begin
      if (free_found) begin
        q_req.kind = ship_pkg::KIND_FREE;
        q_req.way  = free_way;
      end else begin
        q_req.kind = ship_pkg::KIND_SEARCH;
      end
    end else if (is_hit) begin
      q_req.kind = ship_pkg::KIND_HIT;
    end else begin
      q_req.kind = ship_pkg::KIND_FILL;
    end
  end

endmodule

[hw/rtl/ship_queue.sv]
module ship_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ship_pkg::push_ctl_t  push_ctl,
  input  ship_pkg::req_t       push_req,
  output logic                 full,
  input  logic                 pop,
  output ship_pkg::req_t       pop_req,
  output logic                 empty
);

  ship_pkg::req_t                 mem_r [ship_pkg::QUEUE_DEPTH];
  logic [ship_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [ship_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [ship_pkg::QCNT_W-1:0]    cnt_r;
  logic [ship_pkg::QCNT_W-1:0]    cnt_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full    = cnt_r == ship_pkg::QCNT_W'(ship_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push_ctl.push && !push_ctl.full;
  assign do_pop  = pop && !empty;
  assign pop_req = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

[hw/rtl/ship_back.sv]
module ship_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  ship_pkg::req_t                   q_req,
  output logic                             q_pop,
  output logic                             clear_busy,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ship_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ROW   = 2'd2;
  localparam logic [1:0] ST_TRAIN = 2'd3;

  ship_pkg::row_t                row_mem [ship_pkg::NUM_SETS];
  logic [ship_pkg::CTR_W-1:0]    ctr_mem [ship_pkg::SIG_ENTRIES];

  logic [1:0]                    state_r, state_nxt;
  logic [ship_pkg::SET_W-1:0]    clr_idx_r, clr_idx_nxt;
  ship_pkg::req_t                req_r, req_nxt;
  ship_pkg::row_t                row_r, row_nxt;
  logic [ship_pkg::CTR_W-1:0]    ctr_new_r, ctr_new_nxt;
  logic                          out_valid_r;
  ship_pkg::result_t             out_data_r;

  ship_pkg::row_t                row_rd_r;
  logic [ship_pkg::CTR_W-1:0]    ctr_rd_r;

  logic                          row_re, row_we;
  logic [ship_pkg::SET_W-1:0]    row_raddr, row_waddr;
  ship_pkg::row_t                row_wdata;
  logic                          ctr_re, ctr_we;
  logic [ship_pkg::SIG_W-1:0]    ctr_raddr, ctr_waddr;
  logic [ship_pkg::CTR_W-1:0]    ctr_wdata;

  logic                          out_free;
  logic                          load_out;
  ship_pkg::result_t             res;

  logic [ship_pkg::RRPV_MAX:0]   present;
  logic [ship_pkg::RRPV_W-1:0]   top;
  logic [ship_pkg::RRPV_W-1:0]   add;
  ship_pkg::row_t                aged_row;
  logic [ship_pkg::WAY_W-1:0]    aged_victim;

  ship_pkg::way_t                old_way;
  logic [ship_pkg::CTR_W-1:0]    trained;
  logic [ship_pkg::CTR_W-1:0]    new_ctr;
  logic                          hot;

  assign out_free   = !out_valid_r || out_tready;
  assign clear_busy = state_r == ST_CLEAR;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = ship_pkg::OUT_DATA_W'(out_data_r);

  // age the set just enough that its largest RRPV reaches the maximum
  always_comb begin
    present = '0;
    for (int w = 0; w < ship_pkg::NUM_WAYS; w++) begin
      present[row_rd_r[w].rrpv] = 1'b1;
    end
    top = '0;
    for (int l = 1; l <= ship_pkg::RRPV_MAX; l++) begin
      if (present[l]) begin
        top = ship_pkg::RRPV_W'(l);
      end
    end
    add = ship_pkg::RRPV_W'(ship_pkg::RRPV_MAX) - top;
    aged_victim = '0;
    for (int w = ship_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      aged_row[w]      = row_rd_r[w];
      aged_row[w].rrpv = row_rd_r[w].rrpv + add;
      if (row_rd_r[w].rrpv == top) begin
        aged_victim = ship_pkg::WAY_W'(w);
      end
    end
  end

  // train the evicted block's counter and pick the insertion RRPV
  always_comb begin
    old_way = row_r[req_r.way];
    if (old_way.reused) begin
      trained = (ctr_rd_r == ship_pkg::CTR_TOP) ? ctr_rd_r : ctr_rd_r + 1'b1;
    end else begin
      trained = (ctr_rd_r == '0) ? ctr_rd_r : ctr_rd_r - 1'b1;
    end
    if (old_way.valid && old_way.sig == req_r.pc) begin
      new_ctr = trained;
    end else begin
      new_ctr = ctr_new_r;
    end
    hot = new_ctr > ship_pkg::CTR_MID;
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    req_nxt     = req_r;
    row_nxt     = row_r;
    ctr_new_nxt = ctr_new_r;
    q_pop       = 1'b0;
    row_re      = 1'b0;
    row_raddr   = req_r.set_idx;
    row_we      = 1'b0;
    row_waddr   = req_r.set_idx;
    row_wdata   = row_rd_r;
    ctr_re      = 1'b0;
    ctr_raddr   = req_r.pc;
    ctr_we      = 1'b0;
    ctr_waddr   = req_r.pc;
    ctr_wdata   = trained;
    load_out    = 1'b0;
    res         = '0;

    case (state_r)
      ST_CLEAR: begin
        row_we      = 1'b1;
        row_waddr   = clr_idx_r;
        row_wdata   = {ship_pkg::NUM_WAYS{ship_pkg::WAY_RESET}};
        ctr_we      = clr_idx_r < ship_pkg::SIG_ENTRIES;
        ctr_waddr   = clr_idx_r[ship_pkg::SIG_W-1:0];
        ctr_wdata   = ship_pkg::CTR_MID;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == ship_pkg::SET_W'(ship_pkg::NUM_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_req.kind == ship_pkg::KIND_FREE) begin
            if (out_free) begin
              q_pop              = 1'b1;
              load_out           = 1'b1;
              res.victim_way     = q_req.way;
              res.found_free_way = 1'b1;
            end
          end else begin
            q_pop     = 1'b1;
            req_nxt   = q_req;
            row_re    = 1'b1;
            row_raddr = q_req.set_idx;
            ctr_re    = 1'b1;
            ctr_raddr = q_req.pc;
            state_nxt = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        case (req_r.kind)
          ship_pkg::KIND_SEARCH: begin
            if (out_free) begin
              row_we         = 1'b1;
              row_wdata      = aged_row;
              load_out       = 1'b1;
              res.victim_way = aged_victim;
              state_nxt      = ST_IDLE;
            end
          end
          ship_pkg::KIND_HIT: begin
            if (out_free) begin
              row_we                      = 1'b1;
              row_wdata                   = row_rd_r;
              row_wdata[req_r.way].rrpv   = '0;
              row_wdata[req_r.way].reused = 1'b1;
              load_out                    = 1'b1;
              state_nxt                   = ST_IDLE;
            end
          end
          default: begin
            ctr_re      = 1'b1;
            ctr_raddr   = row_rd_r[req_r.way].sig;
            row_nxt     = row_rd_r;
            ctr_new_nxt = ctr_rd_r;
            state_nxt   = ST_TRAIN;
          end
        endcase
      end
      ST_TRAIN: begin
        if (out_free) begin
          ctr_we                      = old_way.valid;
          ctr_waddr                   = old_way.sig;
          ctr_wdata                   = trained;
          row_we                      = 1'b1;
          row_wdata                   = row_r;
          row_wdata[req_r.way].rrpv   = hot ? '0 : ship_pkg::RRPV_W'(ship_pkg::RRPV_MAX - 1);
          row_wdata[req_r.way].valid  = 1'b1;
          row_wdata[req_r.way].reused = 1'b0;
          row_wdata[req_r.way].sig    = req_r.pc;
          load_out                    = 1'b1;
          res.inserted_hot            = hot;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_rd_r <= row_mem[row_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctr_we) begin
      ctr_mem[ctr_waddr] <= ctr_wdata;
    end
    if (ctr_re) begin
      ctr_rd_r <= ctr_mem[ctr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    row_r     <= row_nxt;
    ctr_new_r <= ctr_new_nxt;
    if (load_out) begin
      out_data_r <= res;
    end
  end

endmodule

[hw/rtl/ship_srrip_cache_replacement_top.sv]
// SHiP-style replacement policy with SRRIP for a 2048-set, 16-way cache. Every request on
// the input stream gives exactly one result. After reset the block sweeps its set memory and
// signature counter table once and holds in_tready low during that sweep. Requests
// enter a two-entry queue; the back end then works one request at a time: a victim request that
// finds a free way in its mask is answered without a memory access, a victim search or a hit reads
// the set row and then writes it back, and a fill reads the signature counter table twice through
// its single read port (new signature, then the evicted block's signature) before the write-back.
// A finished result waits in an output register while the next request is already taken in.
module ship_srrip_cache_replacement_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // set_index[10:0], way_index[14:11], pc_low_bits[24:15], way_valid_mask[40:25], zero pad
  input  logic [ship_pkg::IN_DATA_W-1:0]      in_tdata,
  // opcode[0], is_hit[1]
  input  logic [ship_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // victim_way[3:0], found_free_way[4], inserted_hot[5], zero pad
  output logic [ship_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic                 clear_busy;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  logic                 q_push;
  ship_pkg::req_t       push_req;
  ship_pkg::req_t       pop_req;
  ship_pkg::push_ctl_t  push_ctl;

  assign push_ctl.push = q_push;
  assign push_ctl.full = q_full;

  ship_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_req      (push_req)
  );

  ship_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_ctl (push_ctl),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .pop_req  (pop_req),
    .empty    (q_empty)
  );

  ship_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_req      (pop_req),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
